// ===== design/ptc_pkg.sv =====
// Package: constants, types and codes of the preamble timing correlator.
package ptc_pkg;

  localparam int WINDOW_LEN  = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int LOG_N       = $clog2(WINDOW_LEN);
  localparam int LAG_W       = $clog2(WINDOW_LEN + 1);
  localparam int PROD_W      = 2 * SAMPLE_BITS + 1;
  localparam int ACC_RAW     = PROD_W + LOG_N + 1;
  localparam int ACC_W       = (ACC_RAW > 33) ? ACC_RAW : 33;
  localparam int POW_W       = 63;
  localparam int POS_W       = 17;
  localparam int SLOT_W      = 6;
  localparam int START_W     = 16;
  localparam int THR_W       = 8;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RX      = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_START   = 1'd0,
    CFG_PEAK_THRESHOLD = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SAT,
    ST_SQ,
    ST_MAG,
    ST_THR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } sample_t;

  // moves shared by every cell of the chain
  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

endpackage

// ===== design/ptc_in_if.sv =====
// Interface: input channel of the correlator.
interface ptc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               action;
  logic [ptc_pkg::SLOT_W-1:0]               ref_slot;
  logic signed [ptc_pkg::SAMPLE_BITS-1:0]   sample_re;
  logic signed [ptc_pkg::SAMPLE_BITS-1:0]   sample_im;

  modport source (output valid, action, ref_slot, sample_re, sample_im, input ready);
  modport sink   (input valid, action, ref_slot, sample_re, sample_im, output ready);
endinterface

// ===== design/ptc_out_if.sv =====
// Interface: result channel of the correlator.
interface ptc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [31:0]                corr_real;
  logic signed [31:0]                corr_imag;
  logic [ptc_pkg::POS_W-1:0]         lag_position;
  logic                              window_done;
  logic [ptc_pkg::POW_W-1:0]         average_power;
  logic [ptc_pkg::POW_W-1:0]         peak_power;
  logic [ptc_pkg::POS_W-1:0]         peak_position;
  logic                              peak_found;

  modport source (output valid, corr_real, corr_imag, lag_position, window_done,
                  average_power, peak_power, peak_position, peak_found, input ready);
  modport sink   (input valid, corr_real, corr_imag, lag_position, window_done,
                  average_power, peak_power, peak_position, peak_found, output ready);
endinterface

// ===== design/preamble_timing_correlator_unit.sv =====
// Top level: preamble cross-correlation timing search over a chain of cells.
//
//  channel   dir  fields                                          transfer
//  in_ch     in   action, ref_slot, sample_re, sample_im          valid & ready
//  out_ch    out  corr_real/imag, lag_position, window_done,
//                 average_power, peak_power, peak_position,
//                 peak_found                                      valid & ready
//  cfg       in   cfg_we, cfg_index, cfg_data                     cfg_we
//
// Loads, restarts and samples that do not complete a lag are taken in the idle state.
// A sample that completes a lag holds the input while the cell chain makes one rotation
// past the single MAC, then through drain, saturate, square, update, compare and output;
// the result is registered in the output state.
// A result waits in the output register while the next item is taken; the next
// result stalls in the output state until that one is taken.
// Reset (rst, synchronous) clears control and statistics; stores are undefined.
module preamble_timing_correlator_unit (
  input  logic                               clk,
  input  logic                               rst,
  ptc_in_if.sink                             in_ch,
  ptc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptc_pkg::START_W-1:0]        cfg_data
);

  localparam int N = ptc_pkg::WINDOW_LEN;

  ptc_pkg::state_t   state, state_next;
  ptc_pkg::cell_ctl_t ctl;
  ptc_pkg::sample_t  win [N];
  ptc_pkg::sample_t  pre [N];
  ptc_pkg::sample_t  in_sample;
  logic              do_load;

  logic [ptc_pkg::START_W-1:0] search_start;
  logic [ptc_pkg::THR_W-1:0]   peak_threshold;
  logic [ptc_pkg::LAG_W-1:0]   fill_count, lag_count, best_lag, cur_lag;
  logic [ptc_pkg::LAG_W-1:0]   fill_next;
  logic [ptc_pkg::LOG_N-1:0]   cnt;
  logic [ptc_pkg::POW_W-1:0]   power_accum, best_power;
  logic signed [31:0]          sr, si;
  logic [62:0]                 sq_r, sq_i;
  logic                        found;

  logic signed [ptc_pkg::ACC_W-1:0] acc_re, acc_im;
  logic                             in_xfer, mac_valid, mac_clear;

  logic [63:0]              mag_sum, acc_sum;
  logic [ptc_pkg::POW_W-1:0] mag;
  logic signed [63:0]       sr_w, si_w, sq_r_w, sq_i_w;
  logic [70:0]              thr_lhs, thr_rhs;

  assign in_sample.re = in_ch.sample_re;
  assign in_sample.im = in_ch.sample_im;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign fill_next    = (fill_count < ptc_pkg::LAG_W'(N)) ? fill_count + 1'b1 : fill_count;

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < N; i++) begin : g_cell
    ptc_pkg::sample_t nw, np;
    if (i == N - 1) begin : g_last
      assign nw = ctl.rotate ? win[0] : in_sample;
      assign np = pre[0];
    end else begin : g_mid
      assign nw = win[i+1];
      assign np = pre[i+1];
    end
    ptc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (do_load && (32'(in_ch.ref_slot) == i)),
      .load_data (in_sample),
      .nbr_win   (nw),
      .nbr_pre   (np),
      .win       (win[i]),
      .pre       (pre[i])
    );
  end

  ptc_mac u_mac (
    .clk    (clk),
    .clear  (mac_clear),
    .valid  (mac_valid),
    .pre    (pre[0]),
    .win    (win[0]),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    case (state)
      ptc_pkg::ST_IDLE: begin
        if (in_xfer && in_ch.action == ptc_pkg::ACT_RX &&
            lag_count < ptc_pkg::LAG_W'(N) && fill_next == ptc_pkg::LAG_W'(N)) begin
          state_next = ptc_pkg::ST_MAC;
        end
      end
      ptc_pkg::ST_MAC:   if (cnt == ptc_pkg::LOG_N'(N - 1)) state_next = ptc_pkg::ST_DRAIN;
      ptc_pkg::ST_DRAIN: state_next = ptc_pkg::ST_SAT;
      ptc_pkg::ST_SAT:   state_next = ptc_pkg::ST_SQ;
      ptc_pkg::ST_SQ:    state_next = ptc_pkg::ST_MAG;
      ptc_pkg::ST_MAG:   state_next = ptc_pkg::ST_THR;
      ptc_pkg::ST_THR:   state_next = ptc_pkg::ST_OUT;
      ptc_pkg::ST_OUT:   if (!out_ch.valid || out_ch.ready) state_next = ptc_pkg::ST_IDLE;
      default:           state_next = ptc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    do_load     = 1'b0;
    mac_valid   = 1'b0;
    mac_clear   = 1'b0;
    case (state)
      ptc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        mac_clear   = 1'b1;
        do_load     = in_xfer && in_ch.action == ptc_pkg::ACT_LOAD;
        ctl.shift   = in_xfer && in_ch.action == ptc_pkg::ACT_RX &&
                      lag_count < ptc_pkg::LAG_W'(N);
      end
      ptc_pkg::ST_MAC: begin
        ctl.rotate = 1'b1;
        mac_valid  = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- datapath ----------------
  assign sr_w    = 64'(sr);
  assign si_w    = 64'(si);
  assign mag_sum = {1'b0, sq_r} + {1'b0, sq_i};
  assign mag     = mag_sum[63] ? {ptc_pkg::POW_W{1'b1}} : mag_sum[62:0];
  assign acc_sum = {1'b0, power_accum} + 64'(mag >> ptc_pkg::LOG_N);
  assign thr_lhs = {4'b0, best_power, 4'b0};
  assign thr_rhs = 71'(power_accum) * 71'(peak_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ptc_pkg::ST_IDLE;
      search_start   <= '0;
      peak_threshold <= 8'd16;
      fill_count     <= '0;
      lag_count      <= '0;
      power_accum    <= '0;
      best_power     <= '0;
      best_lag       <= '0;
      cnt            <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          ptc_pkg::CFG_SEARCH_START:   search_start   <= cfg_data;
          ptc_pkg::CFG_PEAK_THRESHOLD: peak_threshold <= cfg_data[ptc_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      // output register: load a new result, or empty on a transfer
      if (state == ptc_pkg::ST_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ptc_pkg::ST_IDLE: begin
          cnt <= '0;
          if (in_xfer && in_ch.action == ptc_pkg::ACT_RESTART) begin
            fill_count  <= '0;
            lag_count   <= '0;
            power_accum <= '0;
            best_power  <= '0;
            best_lag    <= '0;
          end else if (ctl.shift) begin
            fill_count <= fill_next;
          end
        end
        ptc_pkg::ST_MAC: cnt <= cnt + 1'b1;
        ptc_pkg::ST_MAG: begin
          power_accum <= acc_sum[63] ? {ptc_pkg::POW_W{1'b1}} : acc_sum[62:0];
          if (mag > best_power) begin
            best_power <= mag;
            best_lag   <= lag_count;
          end
          cur_lag   <= lag_count;
          lag_count <= lag_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ptc_pkg::ST_SAT: begin
        // saturate when the bits from 31 up disagree with the sign
        if (acc_re[ptc_pkg::ACC_W-1:31] != {(ptc_pkg::ACC_W-31){acc_re[ptc_pkg::ACC_W-1]}})
          sr <= acc_re[ptc_pkg::ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
          sr <= acc_re[31:0];
        if (acc_im[ptc_pkg::ACC_W-1:31] != {(ptc_pkg::ACC_W-31){acc_im[ptc_pkg::ACC_W-1]}})
          si <= acc_im[ptc_pkg::ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
          si <= acc_im[31:0];
      end
      ptc_pkg::ST_SQ: begin
        sq_r <= sq_r_w[62:0];
        sq_i <= sq_i_w[62:0];
      end
      ptc_pkg::ST_THR: found <= thr_lhs > thr_rhs;
      ptc_pkg::ST_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          out_ch.corr_real    <= sr;
          out_ch.corr_imag    <= si;
          out_ch.lag_position <= 17'(search_start) + 17'(cur_lag);
          if (lag_count == ptc_pkg::LAG_W'(N)) begin
            out_ch.window_done   <= 1'b1;
            out_ch.average_power <= power_accum;
            out_ch.peak_power    <= best_power;
            out_ch.peak_position <= 17'(search_start) + 17'(best_lag);
            out_ch.peak_found    <= found;
          end else begin
            out_ch.window_done   <= 1'b0;
            out_ch.average_power <= '0;
            out_ch.peak_power    <= '0;
            out_ch.peak_position <= '0;
            out_ch.peak_found    <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign sq_r_w = sr_w * sr_w;
  assign sq_i_w = si_w * si_w;

  // ---------------- assertions ----------------
  a_mac_len: assert property (@(posedge clk) disable iff (rst)
    (state == ptc_pkg::ST_MAC && cnt == ptc_pkg::LOG_N'(N - 1)) |=> state == ptc_pkg::ST_DRAIN)
    else $error("rotation did not end after one full pass");

  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    lag_count <= ptc_pkg::LAG_W'(N) && fill_count <= ptc_pkg::LAG_W'(N))
    else $error("lag or fill count past window length");

  a_lag_needs_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ptc_pkg::ST_MAC) |-> fill_count == ptc_pkg::LAG_W'(N))
    else $error("correlation started before window filled");

  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.window_done) |-> out_ch.peak_power == '0)
    else $error("summary shown before last lag");

endmodule

// ===== design/ptc_cell.sv =====
// One cell of the chain: a preamble sample and a window sample.
module ptc_cell (
  input  logic                clk,
  input  ptc_pkg::cell_ctl_t  ctl,
  input  logic                load,
  input  ptc_pkg::sample_t    load_data,
  input  ptc_pkg::sample_t    nbr_win,
  input  ptc_pkg::sample_t    nbr_pre,
  output ptc_pkg::sample_t    win,
  output ptc_pkg::sample_t    pre
);

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      win <= nbr_win;
      pre <= nbr_pre;
    end else begin
      if (ctl.shift) begin
        win <= nbr_win;
      end
      if (load) begin
        pre <= load_data;
      end
    end
  end

endmodule

// ===== design/ptc_mac.sv =====
// Complex multiply by conjugate and accumulate, one product per cycle while valid is high.
module ptc_mac (
  input  logic                                 clk,
  input  logic                                 clear,
  input  logic                                 valid,
  input  ptc_pkg::sample_t                     pre,
  input  ptc_pkg::sample_t                     win,
  output logic signed [ptc_pkg::ACC_W-1:0]     acc_re,
  output logic signed [ptc_pkg::ACC_W-1:0]     acc_im
);

  logic signed [ptc_pkg::PROD_W-1:0] a, b, c, d;
  logic signed [ptc_pkg::PROD_W-1:0] prod_re, prod_im;
  logic                              prod_valid;

  assign a = ptc_pkg::PROD_W'(pre.re);
  assign b = ptc_pkg::PROD_W'(pre.im);
  assign c = ptc_pkg::PROD_W'(win.re);
  assign d = ptc_pkg::PROD_W'(win.im);

  always_ff @(posedge clk) begin
    prod_re <= a * c + b * d;
    prod_im <= b * c - a * d;
    if (clear) begin
      prod_valid <= 1'b0;
      acc_re     <= '0;
      acc_im     <= '0;
    end else begin
      prod_valid <= valid;
      if (prod_valid) begin
        acc_re <= acc_re + ptc_pkg::ACC_W'(prod_re);
        acc_im <= acc_im + ptc_pkg::ACC_W'(prod_im);
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench for the preamble timing correlator: random and directed searches, scoreboarded.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = ptc_pkg::WINDOW_LEN + 20;

  typedef struct {
    logic [1:0]                             act;
    logic [ptc_pkg::SLOT_W-1:0]             slot;
    logic signed [ptc_pkg::SAMPLE_BITS-1:0] re;
    logic signed [ptc_pkg::SAMPLE_BITS-1:0] im;
  } rx_item_t;

  typedef struct {
    logic signed [31:0]          cre;
    logic signed [31:0]          cim;
    logic [ptc_pkg::POS_W-1:0]   lag_pos;
    logic                        done;
    logic [ptc_pkg::POW_W-1:0]   avg;
    logic [ptc_pkg::POW_W-1:0]   peak;
    logic [ptc_pkg::POS_W-1:0]   peak_pos;
    logic                        found;
  } corr_result_t;

  logic clk, rst;
  logic cfg_we;
  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ptc_pkg::START_W-1:0] cfg_data;

  ptc_in_if  in_ch ();
  ptc_out_if out_ch ();

  preamble_timing_correlator_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // correlator shadow state
  longint pre_re [ptc_pkg::WINDOW_LEN];
  longint pre_im [ptc_pkg::WINDOW_LEN];
  longint win_re [ptc_pkg::WINDOW_LEN];
  longint win_im [ptc_pkg::WINDOW_LEN];
  int unsigned fill_cnt = 0, lag_cnt = 0, best_lag = 0;
  logic [63:0] pow_sum = '0, best_pow = '0;
  logic [ptc_pkg::START_W-1:0] start_reg;
  logic [ptc_pkg::THR_W-1:0] thr_reg;

  rx_item_t pending_items[$];
  rx_item_t cur_item;
  corr_result_t expected_corr[$];
  int errors = 0, n_in = 0, n_out = 0, n_done = 0, n_found = 0, searches = 0;
  int burst_left, gap_left, stall_mode, stall_left, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_corr(input rx_item_t it);
    longint sr, si;
    logic [63:0] mag;
    logic [71:0] lhs, rhs;
    corr_result_t r;
    sr = 0;
    si = 0;
    if (it.act == ptc_pkg::ACT_LOAD) begin
      pre_re[it.slot] = it.re;
      pre_im[it.slot] = it.im;
    end else if (it.act == ptc_pkg::ACT_RESTART) begin
      fill_cnt = 0; lag_cnt = 0; pow_sum = 0; best_pow = 0; best_lag = 0;
    end else if (it.act == ptc_pkg::ACT_RX && lag_cnt < ptc_pkg::WINDOW_LEN) begin
      for (int n = 0; n < ptc_pkg::WINDOW_LEN - 1; n++) begin
        win_re[n] = win_re[n+1];
        win_im[n] = win_im[n+1];
      end
      win_re[ptc_pkg::WINDOW_LEN-1] = it.re;
      win_im[ptc_pkg::WINDOW_LEN-1] = it.im;
      if (fill_cnt < ptc_pkg::WINDOW_LEN) fill_cnt++;
      if (fill_cnt == ptc_pkg::WINDOW_LEN) begin
        // preamble times conjugate of received sample
        for (int n = 0; n < ptc_pkg::WINDOW_LEN; n++) begin
          sr += pre_re[n] * win_re[n] + pre_im[n] * win_im[n];
          si += pre_im[n] * win_re[n] - pre_re[n] * win_im[n];
        end
        if (sr > 64'sh7fffffff) sr = 64'sh7fffffff;
        if (sr < -64'sh80000000) sr = -64'sh80000000;
        if (si > 64'sh7fffffff) si = 64'sh7fffffff;
        if (si < -64'sh80000000) si = -64'sh80000000;
        mag = 64'(sr * sr) + 64'(si * si);
        if (mag > 64'h7fffffffffffffff) mag = 64'h7fffffffffffffff;
        r = '{default: '0};
        r.cre = sr[31:0];
        r.cim = si[31:0];
        r.lag_pos = ptc_pkg::POS_W'(start_reg + lag_cnt);
        pow_sum += mag >> ptc_pkg::LOG_N;
        if (pow_sum > 64'h7fffffffffffffff) pow_sum = 64'h7fffffffffffffff;
        if (mag > best_pow) begin
          best_pow = mag;
          best_lag = lag_cnt;
        end
        lag_cnt++;
        if (lag_cnt >= ptc_pkg::WINDOW_LEN) begin
          lhs = {8'd0, best_pow} << 4;
          rhs = {8'd0, pow_sum} * {64'd0, thr_reg};
          r.done = 1'b1;
          r.avg = pow_sum[ptc_pkg::POW_W-1:0];
          r.peak = best_pow[ptc_pkg::POW_W-1:0];
          r.peak_pos = ptc_pkg::POS_W'(start_reg + best_lag);
          r.found = lhs > rhs;
        end
        expected_corr.push_back(r);
      end
    end
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= ptc_pkg::ACT_LOAD;
      in_ch.ref_slot <= '0;
      in_ch.sample_re <= '0;
      in_ch.sample_im <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_corr(cur_item);
        n_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_ch.action <= cur_item.act;
          in_ch.ref_slot <= cur_item.slot;
          in_ch.sample_re <= cur_item.re;
          in_ch.sample_im <= cur_item.im;
          in_ch.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  // receiver: stall pattern changes every stretch
  always @(posedge clk) begin
    corr_result_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (expected_corr.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none actual lag %0d",
                   $time, out_ch.lag_position);
          errors++;
        end else begin
          e = expected_corr.pop_front();
          check_field("corr_real", 64'(e.cre), 64'(out_ch.corr_real));
          check_field("corr_imag", 64'(e.cim), 64'(out_ch.corr_imag));
          check_field("lag_position", 64'(e.lag_pos), 64'(out_ch.lag_position));
          check_field("window_done", 64'(e.done), 64'(out_ch.window_done));
          check_field("average_power", 64'(e.avg), 64'(out_ch.average_power));
          check_field("peak_power", 64'(e.peak), 64'(out_ch.peak_power));
          check_field("peak_position", 64'(e.peak_pos), 64'(out_ch.peak_position));
          check_field("peak_found", 64'(e.found), 64'(out_ch.peak_found));
          if (e.done) n_done++;
          if (e.found) n_found++;
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [ptc_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2: return 12'sd0;
      default: return ptc_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] a, input int s,
                            input logic signed [ptc_pkg::SAMPLE_BITS-1:0] re,
                            input logic signed [ptc_pkg::SAMPLE_BITS-1:0] im);
    rx_item_t it;
    it.act = a;
    it.slot = ptc_pkg::SLOT_W'(s);
    it.re = re;
    it.im = im;
    pending_items.push_back(it);
  endtask

  // restart, then n_rx samples; 2N samples cover every lag, extras are dropped by the block
  task automatic queue_search(input int n_rx, input bit mixed);
    queue_item(ptc_pkg::ACT_RESTART, $urandom_range(0, 63), pick_sample(), pick_sample());
    for (int i = 0; i < n_rx; i++) begin
      if (mixed && $urandom_range(0, 40) == 0)
        queue_item(ACT_UNUSED, $urandom_range(0, 63), pick_sample(), pick_sample());
      else if (mixed && $urandom_range(0, 30) == 0)
        queue_item(ptc_pkg::ACT_LOAD, $urandom_range(0, 63), pick_sample(), pick_sample());
      queue_item(ptc_pkg::ACT_RX, $urandom_range(0, 63), pick_sample(), pick_sample());
    end
    searches++;
  endtask

  task automatic wait_quiet();
    while (pending_items.size() > 0 || in_ch.valid || expected_corr.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input ptc_pkg::cfg_index_t idx,
                           input logic [ptc_pkg::START_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ptc_pkg::CFG_SEARCH_START) start_reg = val;
    else thr_reg = val[ptc_pkg::THR_W-1:0];
  endtask

  initial begin
    int mode;
    start_reg = '0;
    thr_reg = 8'd16;
    cfg_we <= 1'b0;
    cfg_index <= ptc_pkg::CFG_SEARCH_START;
    cfg_data <= '0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all-zero preamble: no peak, position stays at search start
    for (int s = 0; s < ptc_pkg::WINDOW_LEN; s++)
      queue_item(ptc_pkg::ACT_LOAD, s, 12'sd0, 12'sd0);
    queue_search(2 * ptc_pkg::WINDOW_LEN, 1'b0);
    wait_quiet();
    // full-scale preamble and samples, widest search offset, top threshold
    write_reg(ptc_pkg::CFG_SEARCH_START, 16'hffff);
    write_reg(ptc_pkg::CFG_PEAK_THRESHOLD, 16'd255);
    for (int s = 0; s < ptc_pkg::WINDOW_LEN; s++)
      queue_item(ptc_pkg::ACT_LOAD, s, (s % 2) ? 12'sd2047 : -12'sd2048, -12'sd2048);
    queue_item(ptc_pkg::ACT_RESTART, 0, 12'sd0, 12'sd0);
    for (int i = 0; i < 2 * ptc_pkg::WINDOW_LEN + 4; i++)
      queue_item(ptc_pkg::ACT_RX, i, -12'sd2048, (i % 3 == 0) ? 12'sd2047 : -12'sd2048);
    queue_item(ACT_UNUSED, 63, 12'sd2047, 12'sd2047);
    wait_quiet();
    write_reg(ptc_pkg::CFG_SEARCH_START, 16'd0);
    write_reg(ptc_pkg::CFG_PEAK_THRESHOLD, 16'd0);
    // restart in the middle of a search
    queue_search(ptc_pkg::WINDOW_LEN + 10, 1'b0);
    queue_search(2 * ptc_pkg::WINDOW_LEN, 1'b0);
    wait_quiet();

    while (n_in + pending_items.size() < 1900) begin
      mode = $urandom_range(0, 3);
      write_reg(ptc_pkg::CFG_SEARCH_START, (mode == 0) ? 16'hffff : 16'($urandom));
      write_reg(ptc_pkg::CFG_PEAK_THRESHOLD,
                (mode == 1) ? 16'd0 : 16'($urandom_range(0, 255)));
      for (int k = $urandom_range(1, 3); k > 0; k--)
        queue_search($urandom_range(ptc_pkg::WINDOW_LEN / 2, 2 * ptc_pkg::WINDOW_LEN + 8),
                     1'b1);
      wait_quiet();
    end

    wait_quiet();
    $display("%0d items over %0d searches, %0d lags checked, %0d windows completed,",
             n_in, searches, n_out, n_done);
    $display("%0d with a peak above threshold", n_found);
    if (errors == 0 && expected_corr.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ptc_pkg.sv
design/ptc_in_if.sv
design/ptc_out_if.sv
design/ptc_cell.sv
design/ptc_mac.sv
design/preamble_timing_correlator_unit.sv
test/tb.sv
